@@ design/esw_pkg.sv @@
// Shared types and constants of the stop-and-wait event sender.
`default_nettype none
package esw_pkg;

   localparam int unsigned TIMEOUT_W   = 16;
   localparam int unsigned RETRY_W     = 4;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd3;
   localparam logic [31:0]          CARD_RESET    = 32'hA900_0001;
   localparam logic [2:0]           AUTH_MAX_CODE = 3'd3;

   localparam logic [1:0] AUTH_UNAUTHORIZED = 2'd0;
   localparam logic [1:0] AUTH_AUTHORIZED   = 2'd1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRIES = 1'd1;

   typedef enum logic [2:0] {
      OP_PASSAGE     = 3'd0,
      OP_ACK         = 3'd1,
      OP_DECISION    = 3'd2,
      OP_TICK        = 3'd3,
      OP_AUTH_PLAIN  = 3'd4,
      OP_AUTH_RESULT = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE      = 3'd0,
      KIND_SEND      = 3'd1,
      KIND_RESEND    = 3'd2,
      KIND_DECISION  = 3'd3,
      KIND_GAVE_UP   = 3'd4,
      KIND_AUTH_OK   = 3'd5,
      KIND_AUTH_REJ  = 3'd6,
      KIND_BUSY_DROP = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] now_ms;
      logic [31:0] id;
      logic        from_peer;
      logic        ack_ok;
      logic [2:0]  auth_code;
      logic        reason_none;
      logic [31:0] session_in;
      logic [31:0] card_in;
      logic [31:0] permission_in;
      logic [31:0] counter_in;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] msg_num;
      logic [31:0] evt_num;
      logic [1:0]  auth_out;
      logic [31:0] card_out;
      logic [31:0] session_out;
      logic [31:0] permission_out;
      logic [31:0] counter_out;
      logic        pending_now;
      logic        acked_now;
   } rsp_word_type;

endpackage
`default_nettype wire

@@ design/esw_chan_if.sv @@
// Valid/ready channel carrying one word of a given type.
`default_nettype none
interface esw_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

@@ design/event_sender_stop_and_wait.sv @@
// Stop-and-wait event sender: input register, decision engine, result register.
// A word moves from the input register via the engine to the result register.
// Throughput: one word per cycle when the result side does not stall; each word
// reads and updates the sender state in one engine pass between the registers.
// Reset: synchronous, active high; clears both stages, the sender state and
// loads the configuration defaults (timeout 500 ms, 3 retries).
`default_nettype none
module event_sender_stop_and_wait (
   input  wire logic                            clock,
   input  wire logic                            reset,
   esw_chan_if.sink                             req_ch,
   esw_chan_if.source                           rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [esw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [esw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import esw_pkg::*;

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type result;
   logic         advance;

   // Move the held word on when the result register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.word  = out_word_ff;

   esw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .req_word  (in_word_ff),
      .rsp_word  (result),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Advance the input and result stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_word_ff <= req_ch.word;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

endmodule
`default_nettype wire

@@ design/esw_engine.sv @@
// Sender state, configuration registers and the per-word decision logic.
`default_nettype none
module esw_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                fire,
   input  wire esw_pkg::req_word_type               req_word,
   output esw_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_wr_en,
   input  wire logic [esw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [esw_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import esw_pkg::*;

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [RETRY_W-1:0]   max_retry_ff;

   logic                 pending_ff, pending_in;
   logic                 acked_ff, acked_in;
   logic [RETRY_W-1:0]   retry_ff, retry_in;
   logic [31:0]          sent_time_ff, sent_time_in;
   logic [31:0]          pend_msg_ff, pend_msg_in;
   logic [31:0]          pend_evt_ff, pend_evt_in;
   logic [1:0]           cur_auth_ff, cur_auth_in;
   logic [31:0]          cur_card_ff, cur_card_in;
   logic [31:0]          cur_session_ff, cur_session_in;
   logic [31:0]          cur_perm_ff, cur_perm_in;
   logic [31:0]          cur_counter_ff, cur_counter_in;
   logic [1:0]           held_auth_ff, held_auth_in;
   logic [31:0]          held_card_ff, held_card_in;
   logic [31:0]          held_session_ff, held_session_in;
   logic [31:0]          held_perm_ff, held_perm_in;
   logic [31:0]          held_counter_ff, held_counter_in;

   logic [31:0] elapsed;
   logic        early;
   logic        auth_bad;

   assign elapsed  = req_word.now_ms - sent_time_ff;
   assign early    = elapsed[31] || (elapsed < {16'd0, timeout_ff});
   assign auth_bad = !req_word.reason_none || (req_word.session_in == 32'd0)
                     || (req_word.card_in == 32'd0) || (req_word.permission_in == 32'd0)
                     || (req_word.counter_in == 32'd0);

   // Decide the result and the next state for the word in the input register
   always_comb begin
      pending_in      = pending_ff;
      acked_in        = acked_ff;
      retry_in        = retry_ff;
      sent_time_in    = sent_time_ff;
      pend_msg_in     = pend_msg_ff;
      pend_evt_in     = pend_evt_ff;
      cur_auth_in     = cur_auth_ff;
      cur_card_in     = cur_card_ff;
      cur_session_in  = cur_session_ff;
      cur_perm_in     = cur_perm_ff;
      cur_counter_in  = cur_counter_ff;
      held_auth_in    = held_auth_ff;
      held_card_in    = held_card_ff;
      held_session_in = held_session_ff;
      held_perm_in    = held_perm_ff;
      held_counter_in = held_counter_ff;
      rsp_word        = '0;
      rsp_word.kind   = KIND_NONE;

      unique case (req_word.opcode)
         OP_PASSAGE: begin
            if (pending_ff) begin
               rsp_word.kind = KIND_BUSY_DROP;
            end else begin
               // Fresh ids follow the previous ones; hold auth fields, clear session, permission, counter
               pend_msg_in     = pend_msg_ff + 32'd1;
               pend_evt_in     = pend_evt_ff + 32'd1;
               held_auth_in    = cur_auth_ff;
               held_card_in    = cur_card_ff;
               held_session_in = cur_session_ff;
               held_perm_in    = cur_perm_ff;
               held_counter_in = cur_counter_ff;
               cur_session_in  = '0;
               cur_perm_in     = '0;
               cur_counter_in  = '0;
               if (cur_auth_ff == AUTH_AUTHORIZED) begin
                  cur_auth_in = AUTH_UNAUTHORIZED;
               end
               pending_in   = 1'b1;
               acked_in     = 1'b0;
               sent_time_in = req_word.now_ms;
               retry_in     = '0;
               rsp_word.kind           = KIND_SEND;
               rsp_word.msg_num        = pend_msg_in;
               rsp_word.evt_num        = pend_evt_in;
               rsp_word.auth_out       = cur_auth_ff;
               rsp_word.card_out       = cur_card_ff;
               rsp_word.session_out    = cur_session_ff;
               rsp_word.permission_out = cur_perm_ff;
               rsp_word.counter_out    = cur_counter_ff;
            end
         end
         OP_ACK: begin
            if (req_word.from_peer && pending_ff && (req_word.id == pend_msg_ff)
                && req_word.ack_ok) begin
               acked_in = 1'b1;
            end
         end
         OP_DECISION: begin
            // The last event sent is always the one held in pend_evt
            if (req_word.from_peer && (req_word.id != 32'd0)
                && (req_word.id == pend_evt_ff)) begin
               pending_in       = 1'b0;
               rsp_word.kind    = KIND_DECISION;
               rsp_word.evt_num = req_word.id;
            end
         end
         OP_TICK: begin
            if (pending_ff && !early) begin
               if (retry_ff >= max_retry_ff) begin
                  pending_in       = 1'b0;
                  rsp_word.kind    = KIND_GAVE_UP;
                  rsp_word.msg_num = pend_msg_ff;
                  rsp_word.evt_num = pend_evt_ff;
               end else begin
                  retry_in                = retry_ff + 4'd1;
                  sent_time_in            = req_word.now_ms;
                  rsp_word.kind           = KIND_RESEND;
                  rsp_word.msg_num        = pend_msg_ff;
                  rsp_word.evt_num        = pend_evt_ff;
                  rsp_word.auth_out       = held_auth_ff;
                  rsp_word.card_out       = held_card_ff;
                  rsp_word.session_out    = held_session_ff;
                  rsp_word.permission_out = held_perm_ff;
                  rsp_word.counter_out    = held_counter_ff;
               end
            end
         end
         OP_AUTH_PLAIN: begin
            if (req_word.auth_code <= AUTH_MAX_CODE) begin
               cur_auth_in    = req_word.auth_code[1:0];
               cur_session_in = '0;
               cur_perm_in    = '0;
               cur_counter_in = '0;
               rsp_word.kind  = KIND_AUTH_OK;
            end else begin
               rsp_word.kind  = KIND_AUTH_REJ;
            end
         end
         OP_AUTH_RESULT: begin
            if (req_word.auth_code > AUTH_MAX_CODE) begin
               rsp_word.kind = KIND_AUTH_REJ;
            end else begin
               cur_auth_in    = req_word.auth_code[1:0];
               cur_session_in = '0;
               cur_perm_in    = '0;
               cur_counter_in = '0;
               rsp_word.kind  = KIND_AUTH_OK;
               // An authorized result must be complete, else fall back
               if (req_word.auth_code[1:0] == AUTH_AUTHORIZED) begin
                  if (auth_bad) begin
                     cur_auth_in   = AUTH_UNAUTHORIZED;
                     rsp_word.kind = KIND_AUTH_REJ;
                  end else begin
                     cur_card_in    = req_word.card_in;
                     cur_session_in = req_word.session_in;
                     cur_perm_in    = req_word.permission_in;
                     cur_counter_in = req_word.counter_in;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      rsp_word.pending_now = pending_in;
      rsp_word.acked_now   = acked_in;
   end

   // Hold configuration and sender state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         max_retry_ff    <= RETRY_RESET;
         pending_ff      <= 1'b0;
         acked_ff        <= 1'b0;
         retry_ff        <= '0;
         sent_time_ff    <= '0;
         pend_msg_ff     <= '0;
         pend_evt_ff     <= '0;
         cur_auth_ff     <= AUTH_UNAUTHORIZED;
         cur_card_ff     <= CARD_RESET;
         cur_session_ff  <= '0;
         cur_perm_ff     <= '0;
         cur_counter_ff  <= '0;
         held_auth_ff    <= '0;
         held_card_ff    <= '0;
         held_session_ff <= '0;
         held_perm_ff    <= '0;
         held_counter_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ACK_TIMEOUT: timeout_ff   <= csr_wdata[TIMEOUT_W-1:0];
               CSR_MAX_RETRIES: max_retry_ff <= csr_wdata[RETRY_W-1:0];
               default: begin
               end
            endcase
         end
         if (fire) begin
            pending_ff      <= pending_in;
            acked_ff        <= acked_in;
            retry_ff        <= retry_in;
            sent_time_ff    <= sent_time_in;
            pend_msg_ff     <= pend_msg_in;
            pend_evt_ff     <= pend_evt_in;
            cur_auth_ff     <= cur_auth_in;
            cur_card_ff     <= cur_card_in;
            cur_session_ff  <= cur_session_in;
            cur_perm_ff     <= cur_perm_in;
            cur_counter_ff  <= cur_counter_in;
            held_auth_ff    <= held_auth_in;
            held_card_ff    <= held_card_in;
            held_session_ff <= held_session_in;
            held_perm_ff    <= held_perm_in;
            held_counter_ff <= held_counter_in;
         end
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/event_sender_stop_and_wait_checker.sv @@
// Checker for the stop-and-wait event sender: predicts every result word and compares it.
`default_nettype none
module event_sender_stop_and_wait_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   esw_chan_if                                  req_ch,
   esw_chan_if                                  rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [esw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [esw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                          mismatch_count,
   output int unsigned                          words_awaited,
   output logic [31:0]                          pending_msg_hint,
   output logic [31:0]                          last_evt_hint,
   output logic [31:0]                          sent_at_hint
);
   import esw_pkg::*;

   // Configuration copy
   logic [TIMEOUT_W-1:0] timeout_ms;
   logic [RETRY_W-1:0]   retry_limit;

   // Sender state
   logic        event_pending;
   logic        event_acked;
   logic [3:0]  resends_made;
   logic [31:0] sent_at;
   logic [31:0] pend_msg;
   logic [31:0] pend_evt;
   logic [31:0] last_sent_evt;
   logic [31:0] msg_seq;
   logic [31:0] evt_seq;
   logic [1:0]  auth_verdict;
   logic [31:0] card;
   logic [31:0] session;
   logic [31:0] permission;
   logic [31:0] counter;

   // Auth fields frozen into the pending event
   logic [1:0]  held_auth;
   logic [31:0] held_card;
   logic [31:0] held_session;
   logic [31:0] held_permission;
   logic [31:0] held_counter;

   rsp_word_type outcome_queue[$];
   rsp_word_type oldest_outcome;
   rsp_word_type fresh_outcome;
   req_word_type req_word;
   rsp_word_type rsp_word;

   assign req_word = req_ch.word;
   assign rsp_word = rsp_ch.word;

   task automatic clear_auth_ids();
      session    = '0;
      permission = '0;
      counter    = '0;
   endtask

   task automatic load_event(inout rsp_word_type r);
      r.msg_num        = pend_msg;
      r.evt_num        = pend_evt;
      r.auth_out       = held_auth;
      r.card_out       = held_card;
      r.session_out    = held_session;
      r.permission_out = held_permission;
      r.counter_out    = held_counter;
   endtask

   // Advance the sender state by one input word and build its result word
   task automatic predict_outcome(input req_word_type w, output rsp_word_type r);
      kind_type    kind;
      logic [31:0] elapsed;
      logic        early;
      r       = '0;
      kind    = KIND_NONE;
      elapsed = w.now_ms - sent_at;
      early   = elapsed[31] || (elapsed < {16'd0, timeout_ms});
      case (w.opcode)
         OP_PASSAGE: begin
            if (event_pending) begin
               kind = KIND_BUSY_DROP;
            end else begin
               pend_evt        = evt_seq;
               evt_seq         = evt_seq + 32'd1;
               pend_msg        = msg_seq;
               msg_seq         = msg_seq + 32'd1;
               held_card       = card;
               held_session    = session;
               held_permission = permission;
               held_counter    = counter;
               held_auth       = auth_verdict;
               clear_auth_ids();
               if (auth_verdict == AUTH_AUTHORIZED) auth_verdict = AUTH_UNAUTHORIZED;
               event_pending = 1'b1;
               event_acked   = 1'b0;
               last_sent_evt = pend_evt;
               sent_at       = w.now_ms;
               resends_made  = '0;
               load_event(r);
               kind = KIND_SEND;
            end
         end
         OP_ACK: begin
            if (w.from_peer && event_pending && w.id == pend_msg && w.ack_ok)
               event_acked = 1'b1;
         end
         OP_DECISION: begin
            if (w.from_peer && w.id != 32'd0 && w.id == last_sent_evt) begin
               if (event_pending && w.id == pend_evt) event_pending = 1'b0;
               r.evt_num = w.id;
               kind = KIND_DECISION;
            end
         end
         OP_TICK: begin
            if (event_pending && !early) begin
               if (resends_made >= retry_limit) begin
                  event_pending = 1'b0;
                  r.msg_num     = pend_msg;
                  r.evt_num     = pend_evt;
                  kind = KIND_GAVE_UP;
               end else begin
                  resends_made = resends_made + 4'd1;
                  sent_at      = w.now_ms;
                  load_event(r);
                  kind = KIND_RESEND;
               end
            end
         end
         OP_AUTH_PLAIN: begin
            if (w.auth_code <= AUTH_MAX_CODE) begin
               auth_verdict = w.auth_code[1:0];
               clear_auth_ids();
               kind = KIND_AUTH_OK;
            end else begin
               kind = KIND_AUTH_REJ;
            end
         end
         OP_AUTH_RESULT: begin
            if (w.auth_code > AUTH_MAX_CODE) begin
               kind = KIND_AUTH_REJ;
            end else begin
               auth_verdict = w.auth_code[1:0];
               clear_auth_ids();
               kind = KIND_AUTH_OK;
               if (w.auth_code[1:0] == AUTH_AUTHORIZED) begin
                  // An authorized verdict needs a clean reason and every id set
                  if (!w.reason_none || w.session_in == 32'd0 || w.card_in == 32'd0 ||
                      w.permission_in == 32'd0 || w.counter_in == 32'd0) begin
                     auth_verdict = AUTH_UNAUTHORIZED;
                     kind = KIND_AUTH_REJ;
                  end else begin
                     card       = w.card_in;
                     session    = w.session_in;
                     permission = w.permission_in;
                     counter    = w.counter_in;
                  end
               end
            end
         end
         default: ;
      endcase
      r.kind        = kind;
      r.pending_now = event_pending;
      r.acked_now   = event_acked;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Track configuration, compare result words, then queue predictions
   always @(posedge clock) begin
      if (reset) begin
         timeout_ms      = TIMEOUT_RESET;
         retry_limit     = RETRY_RESET;
         event_pending   = 1'b0;
         event_acked     = 1'b0;
         resends_made    = '0;
         sent_at         = '0;
         pend_msg        = '0;
         pend_evt        = '0;
         last_sent_evt   = '0;
         msg_seq         = 32'd1;
         evt_seq         = 32'd1;
         auth_verdict    = AUTH_UNAUTHORIZED;
         card            = CARD_RESET;
         clear_auth_ids();
         held_auth       = '0;
         held_card       = '0;
         held_session    = '0;
         held_permission = '0;
         held_counter    = '0;
         mismatch_count  = 0;
         outcome_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACK_TIMEOUT: timeout_ms  = csr_wdata[TIMEOUT_W-1:0];
               CSR_MAX_RETRIES: retry_limit = csr_wdata[RETRY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_queue.size() == 0) begin
               $error("result word with no prediction waiting");
               mismatch_count++;
            end else begin
               oldest_outcome = outcome_queue.pop_front();
               check_field("kind", 32'(oldest_outcome.kind), 32'(rsp_word.kind));
               check_field("msg_num", oldest_outcome.msg_num, rsp_word.msg_num);
               check_field("evt_num", oldest_outcome.evt_num, rsp_word.evt_num);
               check_field("auth_out", 32'(oldest_outcome.auth_out), 32'(rsp_word.auth_out));
               check_field("card_out", oldest_outcome.card_out, rsp_word.card_out);
               check_field("session_out", oldest_outcome.session_out, rsp_word.session_out);
               check_field("permission_out", oldest_outcome.permission_out,
                           rsp_word.permission_out);
               check_field("counter_out", oldest_outcome.counter_out, rsp_word.counter_out);
               check_field("pending_now", 32'(oldest_outcome.pending_now),
                           32'(rsp_word.pending_now));
               check_field("acked_now", 32'(oldest_outcome.acked_now),
                           32'(rsp_word.acked_now));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_outcome(req_word, fresh_outcome);
            outcome_queue.push_back(fresh_outcome);
         end
      end
      words_awaited    = outcome_queue.size();
      pending_msg_hint = pend_msg;
      last_evt_hint    = last_sent_evt;
      sent_at_hint     = sent_at;
   end

endmodule
`default_nettype wire

@@ tb/sv/event_sender_stop_and_wait_tb.sv @@
// Testbench top for the stop-and-wait event sender: clock, reset, stimulus and verdict.
`default_nettype none
module event_sender_stop_and_wait_tb;
   import esw_pkg::*;

   localparam int          PHASES       = 5;
   localparam int          PHASE_WORDS  = 290;
   localparam int unsigned CYCLE_LIMIT  = 300000;

   // Opcodes the block has no meaning for
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // Auth codes beyond the accepted range, and one other accepted code
   localparam logic [2:0] AUTH_CODE_FIRST_BAD = AUTH_MAX_CODE + 3'd1;
   localparam logic [2:0] AUTH_CODE_ALL_ONES  = 3'b111;
   localparam logic [2:0] AUTH_CODE_OTHER     = 3'd2;

   // Per phase: timeout, retry limit, sender idle and receiver stall percentages
   localparam logic [15:0] PHASE_TIMEOUT [PHASES] = '{16'd500, 16'd1, 16'd65535, 16'd0, 16'd0};
   localparam logic [3:0]  PHASE_RETRIES [PHASES] = '{4'd3, 4'd0, 4'd15, 4'd2, 4'd0};
   localparam int          PHASE_IDLE    [PHASES] = '{0, 84, 0, 18, 0};
   localparam int          PHASE_STALL   [PHASES] = '{0, 0, 84, 18, 0};

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned mismatch_count;
   int unsigned words_awaited;
   logic [31:0] pending_msg_hint;
   logic [31:0] last_evt_hint;
   logic [31:0] sent_at_hint;

   int unsigned cycle_count;
   int          items_driven;
   int          send_idle_pct;
   int          rsp_stall_pct;
   logic [15:0] cur_timeout;
   logic [3:0]  cur_retries;

   esw_chan_if #(.word_type(req_word_type)) req_ch ();
   esw_chan_if #(.word_type(rsp_word_type)) rsp_ch ();

   event_sender_stop_and_wait u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   event_sender_stop_and_wait_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .words_awaited    (words_awaited),
      .pending_msg_hint (pending_msg_hint),
      .last_evt_hint    (last_evt_hint),
      .sent_at_hint     (sent_at_hint)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("event_sender_stop_and_wait regression: fail");
      $finish;
   end

   // Receiver: stall at random at the current rate
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   function automatic req_word_type make_word(input logic [2:0] op, input logic [31:0] now,
                                              input logic [31:0] ident, input logic peer,
                                              input logic ok, input logic [2:0] code);
      req_word_type w;
      w           = '0;
      w.opcode    = op;
      w.now_ms    = now;
      w.id        = ident;
      w.from_peer = peer;
      w.ack_ok    = ok;
      w.auth_code = code;
      return w;
   endfunction

   function automatic req_word_type auth_result_word(input logic [2:0] code, input logic reason,
                                                     input logic [31:0] s, input logic [31:0] c,
                                                     input logic [31:0] p, input logic [31:0] n);
      req_word_type w;
      w               = make_word(OP_AUTH_RESULT, '0, '0, 1'b0, 1'b0, code);
      w.reason_none   = reason;
      w.session_in    = s;
      w.card_in       = c;
      w.permission_in = p;
      w.counter_in    = n;
      return w;
   endfunction

   function automatic req_word_type noise_word();
      req_word_type w;
      w.opcode        = 3'($urandom_range(0, 7));
      w.now_ms        = $urandom();
      w.id            = $urandom();
      w.from_peer     = 1'($urandom_range(0, 1));
      w.ack_ok        = 1'($urandom_range(0, 1));
      w.auth_code     = 3'($urandom_range(0, 7));
      w.reason_none   = 1'($urandom_range(0, 1));
      w.session_in    = $urandom();
      w.card_in       = $urandom();
      w.permission_in = $urandom();
      w.counter_in    = $urandom();
      return w;
   endfunction

   function automatic logic [31:0] rare_zero();
      return ($urandom_range(0, 14) == 0) ? 32'd0 : $urandom();
   endfunction

   // Pick a tick offset around the timeout, with early, wrapped and far cases
   function automatic logic [31:0] tick_elapsed();
      logic [31:0] span;
      span = {16'd0, cur_timeout};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return span + $urandom_range(0, 3);
         4, 5:       return span;
         6:          return (span == 0) ? 32'd0 : span - 32'd1;
         7:          return (span == 0) ? 32'd0 : $urandom_range(0, span - 1);
         8:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                 : 32'h8000_0000 + $urandom_range(0, 1000);
         default:    return $urandom();
      endcase
   endfunction

   // Present one word after a random gap and hold it until taken; return at a falling edge
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.word  = w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_driven++;
      @(negedge clock);
   endtask

   // Hold off until every predicted result word has come back
   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (words_awaited != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Field extremes, every opcode and the corner cases of acks, ticks and decisions
   task automatic run_directed();
      send_word(make_word(OP_AUTH_PLAIN, '0, '0, 1'b0, 1'b0, AUTH_CODE_ALL_ONES));
      send_word(make_word(OP_AUTH_PLAIN, '0, '0, 1'b0, 1'b0, AUTH_CODE_FIRST_BAD));
      send_word(make_word(OP_AUTH_PLAIN, '0, '0, 1'b0, 1'b0, AUTH_MAX_CODE));
      send_word(auth_result_word({1'b0, AUTH_AUTHORIZED}, 1'b1, 32'hFFFF_FFFF, 32'h8000_0001,
                                 32'h0000_0001, 32'hFFFF_FFFE));
      send_word(make_word(OP_PASSAGE, 32'd0, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_PASSAGE, 32'd7, '0, 1'b1, 1'b1, '0));
      send_word(make_word(OP_ACK, '0, 32'd1, 1'b0, 1'b1, '0));
      send_word(make_word(OP_ACK, '0, 32'd2, 1'b1, 1'b1, '0));
      send_word(make_word(OP_ACK, '0, 32'd1, 1'b1, 1'b0, '0));
      send_word(make_word(OP_TICK, 32'd499, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_TICK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_TICK, 32'd500, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_ACK, '0, 32'd1, 1'b1, 1'b1, '0));
      send_word(make_word(OP_TICK, 32'd1000, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_DECISION, '0, 32'd0, 1'b1, 1'b0, '0));
      send_word(make_word(OP_DECISION, '0, 32'd1, 1'b0, 1'b0, '0));
      send_word(make_word(OP_DECISION, '0, 32'd2, 1'b1, 1'b0, '0));
      send_word(make_word(OP_DECISION, '0, 32'd1, 1'b1, 1'b0, '0));
      send_word(make_word(OP_DECISION, '0, 32'd1, 1'b1, 1'b0, '0));
      send_word(make_word(OP_TICK, 32'd5000, '0, 1'b0, 1'b0, '0));
      send_word(make_word(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '1));
      send_word(make_word(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '1));
      send_word(auth_result_word({1'b0, AUTH_AUTHORIZED}, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4));
      send_word(auth_result_word({1'b0, AUTH_AUTHORIZED}, 1'b1, 32'd1, 32'd2, 32'd3, 32'd0));
      send_word(auth_result_word(AUTH_CODE_OTHER, 1'b1, 32'd9, 32'd9, 32'd9, 32'd9));
      send_word(make_word(OP_PASSAGE, 32'hFFFF_FFF0, '0, 1'b0, 1'b0, '0));
   endtask

   // One passage exchange: optional auth set-up, send, then acks, ticks, decisions and other words
   task automatic run_exchange();
      req_word_type w;
      int           roll;
      if ($urandom_range(0, 1) == 1) begin
         w = noise_word();
         if ($urandom_range(0, 2) == 0) begin
            w.opcode    = OP_AUTH_PLAIN;
            w.auth_code = 3'($urandom_range(0, 4));
         end else begin
            w.opcode        = OP_AUTH_RESULT;
            w.auth_code     = ($urandom_range(0, 3) != 0) ? {1'b0, AUTH_AUTHORIZED}
                                                         : 3'($urandom_range(0, 7));
            w.reason_none   = ($urandom_range(0, 9) != 0);
            w.session_in    = rare_zero();
            w.card_in       = rare_zero();
            w.permission_in = rare_zero();
            w.counter_in    = rare_zero();
         end
         send_word(w);
      end
      w = noise_word();
      w.opcode = OP_PASSAGE;
      send_word(w);
      repeat ($urandom_range(1, 8)) begin
         w    = noise_word();
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            w.opcode = OP_TICK;
            w.now_ms = sent_at_hint + tick_elapsed();
         end else if (roll < 72) begin
            w.opcode    = OP_ACK;
            w.from_peer = ($urandom_range(0, 9) != 0);
            w.ack_ok    = ($urandom_range(0, 6) != 0);
            if ($urandom_range(0, 9) != 0) w.id = pending_msg_hint;
         end else if (roll < 85) begin
            w.opcode    = OP_DECISION;
            w.from_peer = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 2))
               0:       w.id = last_evt_hint;
               1:       w.id = last_evt_hint - 32'd1;
               default: ;
            endcase
         end else if (roll < 92) begin
            w.opcode = OP_PASSAGE;
         end
         send_word(w);
      end
      // Close most exchanges with the matching decision
      if ($urandom_range(0, 9) < 6) begin
         w           = noise_word();
         w.opcode    = OP_DECISION;
         w.from_peer = 1'b1;
         w.id        = last_evt_hint;
         send_word(w);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_ACK_TIMEOUT;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.word   = '0;
      items_driven  = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cur_timeout   = TIMEOUT_RESET;
      cur_retries   = RETRY_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();

      for (int phase = 0; phase < PHASES; phase++) begin
         // Reconfigure only once the block has gone quiet
         if (phase != 0) begin
            drain_results();
            cur_timeout = PHASE_TIMEOUT[phase];
            cur_retries = PHASE_RETRIES[phase];
            if (phase == PHASES - 1) begin
               cur_timeout = 16'($urandom_range(2, 3000));
               cur_retries = 4'($urandom_range(0, 15));
            end
            write_csr(CSR_ACK_TIMEOUT, cur_timeout);
            write_csr(CSR_MAX_RETRIES, CSR_DATA_W'(cur_retries));
         end
         send_idle_pct = PHASE_IDLE[phase];
         rsp_stall_pct = PHASE_STALL[phase];
         while (items_driven < (phase + 1) * PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 75) run_exchange();
            else send_word(noise_word());
         end
      end

      drain_results();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0 && words_awaited == 0) begin
         $display("event_sender_stop_and_wait regression: pass");
      end else begin
         $display("event_sender_stop_and_wait regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
design/esw_pkg.sv
design/esw_chan_if.sv
design/esw_engine.sv
design/event_sender_stop_and_wait.sv
tb/sv/event_sender_stop_and_wait_checker.sv
tb/sv/event_sender_stop_and_wait_tb.sv
